// ----- hw/rtl/oecu_pkg.sv -----
// Package for the occupancy event cell update block.
// Holds item types, command codes, controller states, handshake structs and helpers.
// Used by every module in hw/rtl; depends on nothing.
package oecu_pkg;

    localparam int CELL_COUNT_DEF   = 4096;
    localparam int HISTORY_BITS_DEF = 64;

    localparam int INDEX_W   = 12;
    localparam int MEAS_W    = 8;
    localparam int WEIGHT_W  = 17;
    localparam int CNT_W     = 32;
    localparam int HIST_W    = 64;
    localparam int REG_IDX_W = 1;

    localparam logic [MEAS_W-1:0] OCC_UNKNOWN  = 8'd127;
    localparam logic [MEAS_W-1:0] OCC_OCCUPIED = 8'd255;
    localparam logic [MEAS_W-1:0] OCC_FREE     = 8'd0;
    localparam logic [CNT_W-1:0]  ONE_Q16      = 32'd65536;
    localparam logic [CNT_W-1:0]  LIMIT_RESET  = 32'd1966080000;
    localparam logic [CNT_W-1:0]  FORGET_RESET = 32'd4294108474;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FORGET = 1'b1;

    typedef enum logic [1:0] {
        CMD_PLAIN    = 2'd0,
        CMD_WEIGHTED = 2'd1,
        CMD_RESET    = 2'd2
    } cmd_code_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [INDEX_W-1:0]  cell_index;
        logic [MEAS_W-1:0]   measurement;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [MEAS_W-1:0] occupancy_value;
        logic [CNT_W-1:0]  exit_event_weight;
        logic [CNT_W-1:0]  exit_observations;
        logic [CNT_W-1:0]  entry_event_weight;
        logic [CNT_W-1:0]  entry_observations;
        logic [HIST_W-1:0] event_history;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_MUL,
        ST_MOD_SUB,
        ST_READ,
        ST_UPDATE,
        ST_FILT_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DIV_APP,
        ST_DEC_EV_MUL,
        ST_DEC_EV_APP,
        ST_DEC_OB_MUL,
        ST_DEC_OB_APP,
        ST_WRITE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic mod_mul;
        logic div_start;
        logic idx_cap;
        logic mem_rd;
        logic update;
        logic filt_mul;
        logic div_app;
        logic dec_mul;
        logic dec_app;
        logic dec_sel_obs;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic clear_last;
        logic weighted;
        logic need_clamp;
    } dp_status_t;

    // Unsigned add that saturates at the counter maximum.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/occupancy_event_cell_update.sv -----
// Top level of the occupancy event cell update block.
// Joins oecu_ctrl and oecu_datapath; uses oecu_pkg.
//
// An item is taken when start is high and busy is low. After reset the block
// sweeps the cell memory to its initial contents with busy high; configuration
// writes are taken during that sweep as at any time. Each item first reduces
// the cell index modulo CELL_COUNT by a reciprocal multiply, reads and updates
// the cell, and writes it back; plain, reset and unused commands do no more.
// A weighted update adds one multiply and four decay steps on the shared
// multiplier, and also runs the 32-step serial divider when the observation
// clamp is needed. The result is on the result ports for exactly one cycle
// with result_valid high and must be taken then; busy falls as the strobe
// rises, so the next item may start in that same cycle.
module occupancy_event_cell_update #(
    parameter int CELL_COUNT   = oecu_pkg::CELL_COUNT_DEF,
    parameter int HISTORY_BITS = oecu_pkg::HISTORY_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  oecu_pkg::in_item_t             request,
    output logic                           result_valid,
    output oecu_pkg::out_item_t            result,
    input  logic                           wr_en,
    input  logic [oecu_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [oecu_pkg::CNT_W-1:0]     wr_data
);
    import oecu_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t status;

    oecu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .ctl    (ctl)
    );

    oecu_datapath #(
        .CELL_COUNT   (CELL_COUNT),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .status       (status),
        .request      (request),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result strobe only follows a busy cycle.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without work in progress");

    // One strobe per item: never two in a row.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

endmodule

// ----- hw/rtl/oecu_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Requires the upper dividend half to be below the divisor. Uses oecu_pkg.
module oecu_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           dividend,
    input  logic [oecu_pkg::CNT_W-1:0] divisor,
    output logic                  done,
    output logic [oecu_pkg::CNT_W-1:0] quotient
);
    import oecu_pkg::*;

    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] quo_reg;
    logic [CNT_W-1:0] dsr_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    // One trial subtraction per cycle.
    assign trial = {rem_reg, quo_reg[CNT_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            quo_reg <= dividend[31:0];
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[CNT_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/oecu_datapath.sv -----
// Datapath: cell memory, working cell registers, multiplier, divider and result register.
// Driven by oecu_ctrl through ctrl_cmd_t; uses oecu_pkg and oecu_div.
module oecu_datapath #(
    parameter int CELL_COUNT   = oecu_pkg::CELL_COUNT_DEF,
    parameter int HISTORY_BITS = oecu_pkg::HISTORY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  oecu_pkg::ctrl_cmd_t   ctl,
    output oecu_pkg::dp_status_t  status,
    input  oecu_pkg::in_item_t    request,
    input  logic                  wr_en,
    input  logic [oecu_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [oecu_pkg::CNT_W-1:0]     wr_data,
    output logic                  result_valid,
    output oecu_pkg::out_item_t   result
);
    import oecu_pkg::*;

    localparam int IDX_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int WORD_W = MEAS_W + 4 * CNT_W + HISTORY_BITS;

    // Reciprocal of CELL_COUNT, exact for every 12-bit index.
    localparam int     MOD_K  = INDEX_W + IDX_W;
    localparam int     PROD_W = 2 * INDEX_W + 2;
    localparam longint MOD_M  = ((longint'(1) << MOD_K) + longint'(CELL_COUNT) - 1)
                                / longint'(CELL_COUNT);

    // Configuration registers.
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            factor_reg <= FORGET_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LIMIT:  limit_reg  <= wr_data;
                REG_FORGET: factor_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    // Item registers.
    logic [1:0]          cmd_reg;
    logic [INDEX_W-1:0]  raw_idx_reg;
    logic [MEAS_W-1:0]   meas_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [IDX_W-1:0]    idx_reg;

    // Working cell.
    logic [MEAS_W-1:0]       occ_reg;
    logic [CNT_W-1:0]        xev_reg;
    logic [CNT_W-1:0]        xob_reg;
    logic [CNT_W-1:0]        nev_reg;
    logic [CNT_W-1:0]        nob_reg;
    logic [HISTORY_BITS-1:0] hist_reg;
    logic [63:0]             prod_reg;

    // Clearing sweep counter.
    logic [IDX_W-1:0] clear_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (ctl.clear_wr)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Index reduction: quotient by reciprocal multiply, then the remainder.
    logic [INDEX_W-1:0] mod_q_reg;
    logic [PROD_W-1:0]  mod_prod;
    logic [CNT_W-1:0]   mod_rem;

    assign mod_prod = PROD_W'(raw_idx_reg) * PROD_W'(MOD_M);
    assign mod_rem  = CNT_W'(raw_idx_reg) - CNT_W'(mod_q_reg) * CNT_W'(CELL_COUNT);

    // Divider for the event rescale.
    logic             div_done;
    logic [CNT_W-1:0] div_quo;
    logic [63:0]      div_dividend;
    logic [CNT_W-1:0] div_divisor;
    logic             exit_active;
    logic [CNT_W-1:0] act_ev;
    logic [CNT_W-1:0] act_ob;

    assign exit_active  = occ_reg > OCC_UNKNOWN;
    assign act_ev       = exit_active ? xev_reg : nev_reg;
    assign act_ob       = exit_active ? xob_reg : nob_reg;
    assign div_dividend = prod_reg;
    assign div_divisor  = act_ob;

    oecu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo)
    );

    // Cell memory with registered read.
    logic [WORD_W-1:0] mem [CELL_COUNT];
    logic [WORD_W-1:0] rd_word_reg;
    logic [WORD_W-1:0] init_word;
    logic [WORD_W-1:0] cell_word;
    logic [WORD_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_waddr;
    logic              mem_we;

    assign init_word = {{HISTORY_BITS{1'b0}}, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, OCC_UNKNOWN};
    assign cell_word = {hist_reg, nob_reg, nev_reg, xob_reg, xev_reg, occ_reg};
    assign mem_we    = ctl.clear_wr || ctl.finish;
    assign mem_waddr = ctl.clear_wr ? clear_cnt_reg : idx_reg;
    assign mem_wdata = ctl.clear_wr ? init_word : cell_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.mem_rd)
        begin
            rd_word_reg <= mem[idx_reg];
        end
    end

    // Fields of the word just read.
    logic [MEAS_W-1:0]       rd_occ;
    logic [CNT_W-1:0]        rd_xev;
    logic [CNT_W-1:0]        rd_xob;
    logic [CNT_W-1:0]        rd_nev;
    logic [CNT_W-1:0]        rd_nob;
    logic [HISTORY_BITS-1:0] rd_hist;

    assign rd_occ  = rd_word_reg[MEAS_W-1:0];
    assign rd_xev  = rd_word_reg[MEAS_W +: CNT_W];
    assign rd_xob  = rd_word_reg[MEAS_W + CNT_W +: CNT_W];
    assign rd_nev  = rd_word_reg[MEAS_W + 2*CNT_W +: CNT_W];
    assign rd_nob  = rd_word_reg[MEAS_W + 3*CNT_W +: CNT_W];
    assign rd_hist = rd_word_reg[MEAS_W + 4*CNT_W +: HISTORY_BITS];

    // Event update of the word just read.
    logic [MEAS_W-1:0]       up_occ;
    logic [CNT_W-1:0]        up_xev;
    logic [CNT_W-1:0]        up_xob;
    logic [CNT_W-1:0]        up_nev;
    logic [CNT_W-1:0]        up_nob;
    logic [HISTORY_BITS-1:0] up_hist;
    logic [CNT_W-1:0]        up_w;
    logic                    occ_meas;

    always_comb
    begin
        up_occ   = rd_occ;
        up_xev   = rd_xev;
        up_xob   = rd_xob;
        up_nev   = rd_nev;
        up_nob   = rd_nob;
        up_hist  = rd_hist;
        occ_meas = meas_reg > OCC_UNKNOWN;
        up_w     = (cmd_reg == CMD_PLAIN) ? ONE_Q16 : CNT_W'(weight_reg);
        case (cmd_reg)
            CMD_PLAIN, CMD_WEIGHTED:
            begin
                up_hist = {rd_hist[HISTORY_BITS-2:0], occ_meas};
                if (rd_occ > OCC_UNKNOWN)
                begin
                    up_xob = sat_add(rd_xob, ONE_Q16);
                    if (!occ_meas)
                    begin
                        up_xev = sat_add(rd_xev, up_w);
                        up_occ = OCC_FREE;
                    end
                end
                else if (rd_occ < OCC_UNKNOWN)
                begin
                    up_nob = sat_add(rd_nob, ONE_Q16);
                    if (occ_meas)
                    begin
                        up_nev = sat_add(rd_nev, up_w);
                        up_occ = OCC_OCCUPIED;
                    end
                end
                else
                begin
                    up_occ = meas_reg;
                end
            end
            CMD_RESET:
            begin
                up_occ = OCC_UNKNOWN;
                up_xev = ONE_Q16;
                up_xob = ONE_Q16;
                up_nev = ONE_Q16;
                up_nob = ONE_Q16;
            end
            default: ;
        endcase
    end

    // Decay of the inactive side toward 1.0.
    logic [CNT_W-1:0] dec_x;
    logic             dec_up;
    logic [CNT_W-1:0] dec_diff;
    logic [CNT_W-1:0] dec_d;
    logic [CNT_W-1:0] dec_res;

    always_comb
    begin
        if (exit_active)
        begin
            dec_x = ctl.dec_sel_obs ? nob_reg : nev_reg;
        end
        else
        begin
            dec_x = ctl.dec_sel_obs ? xob_reg : xev_reg;
        end
        dec_up   = dec_x >= ONE_Q16;
        dec_diff = dec_up ? (dec_x - ONE_Q16) : (ONE_Q16 - dec_x);
        dec_d    = prod_reg[63:32];
        dec_res  = dec_up ? (ONE_Q16 + dec_d) : (ONE_Q16 - dec_d);
    end

    // Multiplier shared by the filter and decay steps, registered.
    logic [CNT_W-1:0] mul_a;
    logic [CNT_W-1:0] mul_b;

    assign mul_a = ctl.filt_mul ? act_ev : dec_diff;
    assign mul_b = ctl.filt_mul ? limit_reg : factor_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.filt_mul || ctl.dec_mul)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
    end

    // Item capture and working cell updates.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= request.command;
            raw_idx_reg <= request.cell_index;
            meas_reg    <= request.measurement;
            weight_reg  <= request.weight;
        end
        if (ctl.mod_mul)
        begin
            mod_q_reg <= INDEX_W'(mod_prod >> MOD_K);
        end
        if (ctl.idx_cap)
        begin
            idx_reg <= mod_rem[IDX_W-1:0];
        end
        if (ctl.update)
        begin
            occ_reg  <= up_occ;
            xev_reg  <= up_xev;
            xob_reg  <= up_xob;
            nev_reg  <= up_nev;
            nob_reg  <= up_nob;
            hist_reg <= up_hist;
        end
        else if (ctl.div_app)
        begin
            if (exit_active)
            begin
                xev_reg <= div_quo;
                xob_reg <= limit_reg;
            end
            else
            begin
                nev_reg <= div_quo;
                nob_reg <= limit_reg;
            end
        end
        else if (ctl.dec_app)
        begin
            case ({exit_active, ctl.dec_sel_obs})
                2'b10:   nev_reg <= dec_res;
                2'b11:   nob_reg <= dec_res;
                2'b00:   xev_reg <= dec_res;
                default: xob_reg <= dec_res;
            endcase
        end
    end

    // Result register and strobe.
    logic      valid_reg;
    out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            result_reg.occupancy_value    <= occ_reg;
            result_reg.exit_event_weight  <= xev_reg;
            result_reg.exit_observations  <= xob_reg;
            result_reg.entry_event_weight <= nev_reg;
            result_reg.entry_observations <= nob_reg;
            result_reg.event_history      <= HIST_W'(hist_reg);
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    // Status back to the controller.
    assign status.div_done   = div_done;
    assign status.clear_last = clear_cnt_reg == IDX_W'(CELL_COUNT - 1);
    assign status.weighted   = cmd_reg == CMD_WEIGHTED;
    assign status.need_clamp = act_ob > limit_reg;

endmodule

// ----- hw/rtl/oecu_ctrl.sv -----
// Controller state machine for the occupancy event cell update block.
// Sequences oecu_datapath through ctrl_cmd_t; uses oecu_pkg.
module oecu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  oecu_pkg::dp_status_t status,
    output oecu_pkg::ctrl_cmd_t  ctl
);
    import oecu_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register; reset begins the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_MOD_MUL;
                end
            end
            ST_MOD_MUL:
            begin
                ctl.mod_mul = 1'b1;
                state_next  = ST_MOD_SUB;
            end
            ST_MOD_SUB:
            begin
                ctl.idx_cap = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                ctl.mem_rd = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ctl.update = 1'b1;
                state_next = status.weighted ? ST_FILT_MUL : ST_WRITE;
            end
            ST_FILT_MUL:
            begin
                ctl.filt_mul = 1'b1;
                state_next   = status.need_clamp ? ST_DIV_START : ST_DEC_EV_MUL;
            end
            ST_DIV_START:
            begin
                ctl.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    ctl.div_app = 1'b1;
                    state_next  = ST_DEC_EV_MUL;
                end
            end
            ST_DEC_EV_MUL:
            begin
                ctl.dec_mul = 1'b1;
                state_next  = ST_DEC_EV_APP;
            end
            ST_DEC_EV_APP:
            begin
                ctl.dec_app = 1'b1;
                state_next  = ST_DEC_OB_MUL;
            end
            ST_DEC_OB_MUL:
            begin
                ctl.dec_mul     = 1'b1;
                ctl.dec_sel_obs = 1'b1;
                state_next      = ST_DEC_OB_APP;
            end
            ST_DEC_OB_APP:
            begin
                ctl.dec_app     = 1'b1;
                ctl.dec_sel_obs = 1'b1;
                state_next      = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctl.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;

endmodule

// ----- tb/tb_occupancy_event_cell_update.sv -----
// Testbench for the occupancy event cell update block.
// Drives command items and register writes and checks every result against an
// in-bench model of the cell store; depends on oecu_pkg and the block's RTL.
module tb_occupancy_event_cell_update;
    timeunit 1ns;
    timeprecision 1ps;
    import oecu_pkg::*;

    localparam int CELLS = 4096;
    localparam longint CYCLE_LIMIT = 2000000;

    // Cell store model and the results it predicts, checked in order.
    class cell_scoreboard;
        logic [7:0]  occ[CELLS];
        logic [31:0] xev[CELLS];
        logic [31:0] xob[CELLS];
        logic [31:0] nev[CELLS];
        logic [31:0] nob[CELLS];
        logic [63:0] hist[CELLS];
        logic [31:0] obs_limit;
        logic [31:0] forget;
        out_item_t   pending[$];
        int          errors;

        function new();
            errors = 0;
            obs_limit = LIMIT_RESET;
            forget = FORGET_RESET;
            for (int i = 0; i < CELLS; i++)
            begin
                clear_cell(i);
                hist[i] = '0;
            end
        endfunction

        function void clear_cell(int i);
            occ[i] = OCC_UNKNOWN;
            xev[i] = ONE_Q16;
            xob[i] = ONE_Q16;
            nev[i] = ONE_Q16;
            nob[i] = ONE_Q16;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // Pull a counter toward 1.0 by the forget factor, truncating toward 1.0.
        function logic [31:0] toward_one(logic [31:0] x);
            logic [63:0] d;
            if (x >= ONE_Q16)
            begin
                d = (64'(x - ONE_Q16) * 64'(forget)) >> 32;
                return ONE_Q16 + d[31:0];
            end
            d = (64'(ONE_Q16 - x) * 64'(forget)) >> 32;
            return ONE_Q16 - d[31:0];
        endfunction

        function void clamp(ref logic [31:0] ev, ref logic [31:0] ob);
            logic [63:0] p;
            if (ob > obs_limit)
            begin
                p = 64'(ev) * 64'(obs_limit);
                ev = 32'(p / 64'(ob));
                ob = obs_limit;
            end
        endfunction

        function void note_item(in_item_t it);
            int i;
            logic hit;
            logic [31:0] w;
            out_item_t r;
            i = it.cell_index;
            hit = it.measurement > OCC_UNKNOWN;
            w = (it.command == CMD_WEIGHTED) ? 32'(it.weight) : ONE_Q16;
            if (it.command == CMD_PLAIN || it.command == CMD_WEIGHTED)
            begin
                hist[i] = {hist[i][62:0], hit};
                if (occ[i] > OCC_UNKNOWN)
                begin
                    xob[i] = add_sat(xob[i], ONE_Q16);
                    if (!hit)
                    begin
                        xev[i] = add_sat(xev[i], w);
                        occ[i] = OCC_FREE;
                    end
                end
                else if (occ[i] < OCC_UNKNOWN)
                begin
                    nob[i] = add_sat(nob[i], ONE_Q16);
                    if (hit)
                    begin
                        nev[i] = add_sat(nev[i], w);
                        occ[i] = OCC_OCCUPIED;
                    end
                end
                else
                    occ[i] = it.measurement;
            end
            // Weighted updates filter the active side and decay the other one.
            if (it.command == CMD_WEIGHTED)
            begin
                if (occ[i] > OCC_UNKNOWN)
                begin
                    clamp(xev[i], xob[i]);
                    nev[i] = toward_one(nev[i]);
                    nob[i] = toward_one(nob[i]);
                end
                else
                begin
                    clamp(nev[i], nob[i]);
                    xev[i] = toward_one(xev[i]);
                    xob[i] = toward_one(xob[i]);
                end
            end
            else if (it.command == CMD_RESET)
                clear_cell(i);
            r.occupancy_value = occ[i];
            r.exit_event_weight = xev[i];
            r.exit_observations = xob[i];
            r.entry_event_weight = nev[i];
            r.entry_observations = nob[i];
            r.event_history = hist[i];
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none expected: %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.occupancy_value !== e.occupancy_value)
                report("occupancy_value", e.occupancy_value, got.occupancy_value);
            if (got.exit_event_weight !== e.exit_event_weight)
                report("exit_event_weight", e.exit_event_weight, got.exit_event_weight);
            if (got.exit_observations !== e.exit_observations)
                report("exit_observations", e.exit_observations, got.exit_observations);
            if (got.entry_event_weight !== e.entry_event_weight)
                report("entry_event_weight", e.entry_event_weight, got.entry_event_weight);
            if (got.entry_observations !== e.entry_observations)
                report("entry_observations", e.entry_observations, got.entry_observations);
            if (got.event_history !== e.event_history)
                report("event_history", e.event_history, got.event_history);
        endfunction

        function void report(string f, logic [63:0] e, logic [63:0] a);
            $display("%0t: %s expected %h actual %h", $time, f, e, a);
            errors++;
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    in_item_t    request = '0;
    logic        result_valid;
    out_item_t   result;
    logic        wr_en = 0;
    logic [REG_IDX_W-1:0] wr_index = REG_LIMIT;
    logic [31:0] wr_data = '0;
    longint      cycles = 0;
    cell_scoreboard sb = new();

    occupancy_event_cell_update DUT (.*);

    always #2 clk = ~clk;

    // Results are sampled at the edge that ends their strobe cycle.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && result_valid)
            sb.check_result(result);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[occupancy_event_cell_update] ERROR");
            $finish;
        end
    end

    // Issue one item and hold it until the block takes it. The block stays
    // busy after accepting, so the extra edge at the end costs no throughput.
    task automatic send_item(logic [1:0] cmd, logic [11:0] idx, logic [7:0] meas,
                             logic [16:0] w);
        in_item_t it;
        it.command = cmd;
        it.cell_index = idx;
        it.measurement = meas;
        it.weight = w;
        request <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every result, then let any work in flight settle.
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_LIMIT)
            sb.obs_limit = v;
        else
            sb.forget = v;
        @(posedge clk);
    endtask

    task automatic random_item(int hot);
        logic [1:0] cmd;
        logic [16:0] w;
        int r;
        r = $urandom_range(0, 99);
        cmd = (r < 30) ? CMD_PLAIN : (r < 90) ? CMD_WEIGHTED : (r < 97) ? CMD_RESET : 2'd3;
        w = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        send_item(cmd, (hot != 0) ? 12'($urandom_range(0, 15)) : 12'($urandom),
                  8'($urandom), w);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(REG_LIMIT, 32'd3 << 16);
        write_reg(REG_FORGET, 32'hFFFF_FFFF);

        // Directed: unknown cell, both transitions, clamp, reset, unused command.
        send_item(CMD_PLAIN, 12'd0, 8'd255, 17'd0);
        send_item(CMD_WEIGHTED, 12'd0, 8'd0, 17'h1FFFF);
        send_item(CMD_WEIGHTED, 12'd0, 8'd128, 17'd65536);
        send_item(CMD_WEIGHTED, 12'd0, 8'd127, 17'd0);
        send_item(CMD_PLAIN, 12'd0, 8'd200, 17'd0);
        send_item(CMD_WEIGHTED, 12'd0, 8'd255, 17'd1);
        send_item(2'd3, 12'd0, 8'd0, 17'd0);
        send_item(CMD_RESET, 12'd0, 8'd255, 17'h1FFFF);
        send_item(CMD_PLAIN, 12'd0, 8'd0, 17'd0);
        send_item(CMD_WEIGHTED, 12'd4095, 8'd127, 17'd65536);
        send_item(CMD_WEIGHTED, 12'd4095, 8'd1, 17'h10000);
        send_item(CMD_PLAIN, 12'd4095, 8'd254, 17'd0);
        send_item(CMD_RESET, 12'd4095, 8'd0, 17'd0);
        send_item(CMD_PLAIN, 12'hAAA, 8'h55, 17'h0AAAA);
        send_item(CMD_WEIGHTED, 12'h555, 8'hAA, 17'h15555);
        drain();

        // Random phases across register settings, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1: begin write_reg(REG_LIMIT, 32'd0); write_reg(REG_FORGET, 32'd0); end
                2: begin write_reg(REG_LIMIT, 32'hFFFF_FFFF); write_reg(REG_FORGET, 32'd0); end
                3: begin write_reg(REG_LIMIT, LIMIT_RESET); write_reg(REG_FORGET, FORGET_RESET); end
                default: begin
                    write_reg(REG_LIMIT, ($urandom_range(0, 1) != 0) ? $urandom
                                                                      : $urandom_range(0, 20) << 16);
                    write_reg(REG_FORGET, $urandom);
                end
            endcase
            for (int k = 0; k < 200; k++)
            begin
                random_item(ph % 2 == 0);
                idle_gap();
            end
            drain();
        end

        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("[occupancy_event_cell_update] OK");
        else
            $display("[occupancy_event_cell_update] ERROR");
        $finish;
    end
endmodule
